### rtl/sqfs_pkg.sv
// ============================================================================
// sqfs_pkg
// Shared types, constants and table builders for the square wave Fourier
// synthesizer: coefficient table, quarter-wave sine generator, register codes.
// ============================================================================
package sqfs_pkg;

    // pi in Q2.30
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam int DEFAULT_MAX_HARMONICS  = 64;
    localparam int DEFAULT_SINE_ADDR_BITS = 10;

    // Field widths
    localparam int PHASE_W   = 32;
    localparam int VALUE_W   = 20;
    localparam int HARM_W    = 7;
    localparam int COEFF_W   = 16;   // unsigned Q0.16, largest entry 41722
    localparam int SINE_W    = 18;   // signed Q1.16, range +/-65536
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Coefficient table covers the largest allowed harmonic count
    localparam int COEFF_DEPTH  = 256;
    localparam int COEFF_ADDR_W = 8;

    // Register reset values
    localparam logic [HARM_W-1:0]  RST_HARM_COUNT  = HARM_W'(15);
    localparam logic [PHASE_W-1:0] RST_PHASE_STEP  = PHASE_W'(4294967);
    localparam logic [PHASE_W-1:0] RST_START_PHASE = '0;
    localparam logic [VALUE_W-1:0] RST_DC_OFFSET   = '0;

    localparam int SAMPLE_MAX = 524287;
    localparam int SAMPLE_MIN = -524288;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HARM_COUNT  = 2'd0,
        REG_PHASE_STEP  = 2'd1,
        REG_START_PHASE = 2'd2,
        REG_DC_OFFSET   = 2'd3
    } reg_index_t;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

    // floor(2^48 / pi_q30); for odd k, coefficient k is (floor(COEFF_NUM / k) + 1) >> 1, else 0
    localparam longint unsigned COEFF_NUM   = (64'd1 << 48) / PI_Q30;
    localparam int              COEFF_NUM_W = $clog2(COEFF_NUM + 1);

    typedef logic [COEFF_W-1:0] coeff_table_t [COEFF_DEPTH];

    function automatic coeff_table_t build_coeff_table();
        coeff_table_t     tbl;
        longint unsigned  rem;
        longint unsigned  quo;
        longint unsigned  k;
        for (int i = 0; i < COEFF_DEPTH; i++) begin
            k = longint'(i) + 1;
            if (k[0]) begin
                // shift-subtract division of COEFF_NUM by k
                rem = 0;
                quo = 0;
                for (int b = COEFF_NUM_W - 1; b >= 0; b--) begin
                    rem = (rem << 1) | ((COEFF_NUM >> b) & 64'd1);
                    quo = quo << 1;
                    if (rem >= k) begin
                        rem = rem - k;
                        quo = quo | 64'd1;
                    end
                end
                tbl[i] = COEFF_W'((quo + 1) >> 1);
            end else begin
                tbl[i] = '0;
            end
        end
        return tbl;
    endfunction

    localparam coeff_table_t COEFF_TABLE = build_coeff_table();

    // (2n)(2n+1) for the Taylor terms x^3 .. x^25
    localparam longint unsigned TAYLOR_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // First quarter of the sine wave at point j of a table of 2^addr_bits
    function automatic logic signed [SINE_W-1:0] quarter_sine(input int unsigned j,
                                                              input int unsigned addr_bits);
        longint unsigned x;
        longint unsigned term;
        longint          s;
        x    = (64'd2 * PI_Q30 * longint'(j)) >> addr_bits;
        term = x;
        s    = longint'(x);
        for (int n = 0; n < 12; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[n];
            if (n % 2 == 0) begin
                s = s - longint'(term);
            end else begin
                s = s + longint'(term);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        s = (s + 8192) >>> 14;
        if (s > 65536) begin
            s = 65536;
        end
        return SINE_W'(s);
    endfunction

endpackage

### rtl/sqfs_sine_rom.sv
// ============================================================================
// sqfs_sine_rom
// Full-wave sine ROM, signed Q1.16, built at elaboration from the quarter
// wave by symmetry. One read per cycle, registered output.
// ============================================================================
module sqfs_sine_rom #(
    parameter int SINE_ADDR_BITS = sqfs_pkg::DEFAULT_SINE_ADDR_BITS
) (
    input  logic                                  aclk,
    input  logic [SINE_ADDR_BITS-1:0]             rd_addr,
    output logic signed [sqfs_pkg::SINE_W-1:0]    rd_data
);

    localparam int SINE_SIZE = 1 << SINE_ADDR_BITS;
    localparam int QUARTER   = SINE_SIZE >> 2;

    typedef logic signed [sqfs_pkg::SINE_W-1:0] sine_table_t [SINE_SIZE];

    function automatic sine_table_t build_sine_table();
        sine_table_t              tbl;
        int unsigned              quad;
        int unsigned              r;
        logic signed [sqfs_pkg::SINE_W-1:0] v;
        for (int i = 0; i < SINE_SIZE; i++) begin
            quad = i / QUARTER;
            r    = i % QUARTER;
            if (quad % 2 == 1) begin
                v = sqfs_pkg::quarter_sine(QUARTER - r, SINE_ADDR_BITS);
            end else begin
                v = sqfs_pkg::quarter_sine(r, SINE_ADDR_BITS);
            end
            tbl[i] = (quad >= 2) ? -v : v;
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    always_ff @(posedge aclk) begin
        rd_data <= SINE_TABLE[rd_addr];
    end

endmodule

### rtl/sqfs_mac.sv
// ============================================================================
// sqfs_mac
// Shared multiply-accumulate unit: registered coeff*sine product, then an
// exact running sum of the products.
// ============================================================================
module sqfs_mac #(
    parameter int ACC_W = 44
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sqfs_pkg::mac_ctrl_t                   ctrl,
    input  logic [sqfs_pkg::COEFF_W-1:0]          coeff,
    input  logic signed [sqfs_pkg::SINE_W-1:0]    sine,
    output logic signed [ACC_W-1:0]               acc,
    output logic                                  busy
);

    localparam int PROD_W = sqfs_pkg::COEFF_W + 1 + sqfs_pkg::SINE_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= signed'({1'b0, coeff}) * sine;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end else if (ctrl.clear) begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end else begin
            prod_valid_reg <= ctrl.valid;
            if (prod_valid_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_valid_reg;

endmodule

### rtl/square_wave_fourier_synth.sv
// Operation: n = min(harm_count, MAX_HARMONICS); the sequencer issues one harmonic per
//   cycle to the shared multiply-accumulate unit through the ROM and product steps, then
//   rounds the sum before m_tvalid. s_tready is high only while idle. A finished sample
//   waits in the output register; the next sample is held in ST_EMIT until that
//   register is free.
// Reset: synchronous active-low aresetn restores register defaults, zeroes phase.
// ============================================================================
// square_wave_fourier_synth
// Band-limited square wave generator: sums coeff[k]*sin(2*pi*k*phase) over
// harmonics with one shared MAC, adds a DC offset and saturates to Q3.16.
// ============================================================================
module square_wave_fourier_synth #(
    parameter int MAX_HARMONICS  = sqfs_pkg::DEFAULT_MAX_HARMONICS,
    parameter int SINE_ADDR_BITS = sqfs_pkg::DEFAULT_SINE_ADDR_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [sqfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sqfs_pkg::CFG_DAT_W-1:0]      cfg_wdata,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] restart
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,   // [19:0] sample_value,
                                                           // [51:20] sample_phase
    output logic [0:0]                          m_tuser    // [0] saturated
);

    localparam int PHASE_W  = sqfs_pkg::PHASE_W;
    localparam int VALUE_W  = sqfs_pkg::VALUE_W;
    localparam int HARM_W   = sqfs_pkg::HARM_W;
    localparam int KW       = $clog2(MAX_HARMONICS + 1);
    localparam int CW       = (KW > HARM_W) ? KW : HARM_W;
    localparam int PROD_W   = sqfs_pkg::COEFF_W + 1 + sqfs_pkg::SINE_W;
    localparam int ACC_W    = PROD_W + $clog2(MAX_HARMONICS) + 1;
    localparam int RND_W    = ACC_W - 16;
    localparam int SUM_W    = ((RND_W > VALUE_W) ? RND_W : VALUE_W) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(sqfs_pkg::SAMPLE_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(sqfs_pkg::SAMPLE_MIN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ROUND,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [HARM_W-1:0]         harm_count_reg;
    logic [PHASE_W-1:0]        phase_step_reg;
    logic [PHASE_W-1:0]        start_phase_reg;
    logic signed [VALUE_W-1:0] dc_offset_reg;

    // sequencer
    logic [PHASE_W-1:0]        phase_accum_reg;
    logic [PHASE_W-1:0]        phase_reg;      // phase of this sample
    logic [PHASE_W-1:0]        ph_reg;         // k * phase mod 2^32
    logic [KW-1:0]             k_reg;
    logic [KW-1:0]             n_reg;
    logic                      issue_reg;
    logic                      v1_reg;         // ROM data and coeff_reg valid
    logic [sqfs_pkg::COEFF_W-1:0] coeff_reg;
    logic signed [SUM_W-1:0]   sum_reg;

    // output register
    logic                      m_tvalid_reg;
    logic signed [VALUE_W-1:0] value_out_reg;
    logic [PHASE_W-1:0]        phase_out_reg;
    logic                      sat_out_reg;

    logic                      accept;
    logic [PHASE_W-1:0]        phase_now;
    logic [CW-1:0]             hc_ext;
    logic [KW-1:0]             n_now;
    logic [sqfs_pkg::COEFF_ADDR_W-1:0] coeff_addr;
    logic signed [sqfs_pkg::SINE_W-1:0] sine_data;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [RND_W-1:0]   rounded;
    logic                      mac_busy;
    logic                      run_done;
    logic                      out_free;
    sqfs_pkg::mac_ctrl_t       mac_ctrl;

    assign accept    = s_tvalid && s_tready;
    assign phase_now = s_tdata[0] ? start_phase_reg : phase_accum_reg;
    assign hc_ext    = CW'(harm_count_reg);
    assign n_now     = (hc_ext > CW'(MAX_HARMONICS)) ? KW'(MAX_HARMONICS) : KW'(hc_ext);
    assign coeff_addr = sqfs_pkg::COEFF_ADDR_W'(k_reg - KW'(1));
    assign run_done  = !issue_reg && !v1_reg && !mac_busy;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign acc_rnd   = acc + ACC_W'(32768);
    assign rounded   = acc_rnd[ACC_W-1:16];

    assign mac_ctrl.clear = accept;
    assign mac_ctrl.valid = v1_reg;

    sqfs_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine_rom (
        .aclk    (aclk),
        .rd_addr (ph_reg[PHASE_W-1 -: SINE_ADDR_BITS]),
        .rd_data (sine_data)
    );

    sqfs_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .coeff   (coeff_reg),
        .sine    (sine_data),
        .acc     (acc),
        .busy    (mac_busy)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            harm_count_reg  <= sqfs_pkg::RST_HARM_COUNT;
            phase_step_reg  <= sqfs_pkg::RST_PHASE_STEP;
            start_phase_reg <= sqfs_pkg::RST_START_PHASE;
            dc_offset_reg   <= sqfs_pkg::RST_DC_OFFSET;
        end else if (cfg_wr_en) begin
            case (sqfs_pkg::reg_index_t'(cfg_index))
                sqfs_pkg::REG_HARM_COUNT:  harm_count_reg  <= cfg_wdata[HARM_W-1:0];
                sqfs_pkg::REG_PHASE_STEP:  phase_step_reg  <= cfg_wdata[PHASE_W-1:0];
                sqfs_pkg::REG_START_PHASE: start_phase_reg <= cfg_wdata[PHASE_W-1:0];
                sqfs_pkg::REG_DC_OFFSET:   dc_offset_reg   <= cfg_wdata[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath registers of the sequencer (no reset needed)
    always_ff @(posedge aclk) begin
        if (accept) begin
            phase_reg <= phase_now;
            ph_reg    <= phase_now;
            n_reg     <= n_now;
        end else if (state_reg == ST_RUN && issue_reg) begin
            ph_reg <= ph_reg + phase_reg;
        end
        if (state_reg == ST_RUN && issue_reg) begin
            coeff_reg <= sqfs_pkg::COEFF_TABLE[coeff_addr];
        end
        if (state_reg == ST_ROUND) begin
            sum_reg <= SUM_W'(rounded) + SUM_W'(dc_offset_reg);
        end
        if (state_reg == ST_EMIT && out_free) begin
            phase_out_reg <= phase_reg;
            if (sum_reg > SAT_HI) begin
                value_out_reg <= VALUE_W'(SAT_HI);
                sat_out_reg   <= 1'b1;
            end else if (sum_reg < SAT_LO) begin
                value_out_reg <= VALUE_W'(SAT_LO);
                sat_out_reg   <= 1'b1;
            end else begin
                value_out_reg <= VALUE_W'(sum_reg);
                sat_out_reg   <= 1'b0;
            end
        end
    end

    // state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_accum_reg <= '0;
            k_reg           <= '0;
            issue_reg       <= 1'b0;
            v1_reg          <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    v1_reg <= 1'b0;
                    if (accept) begin
                        phase_accum_reg <= phase_now + phase_step_reg;
                        k_reg           <= KW'(1);
                        issue_reg       <= (n_now != '0);
                        state_reg       <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    v1_reg <= issue_reg;
                    if (issue_reg) begin
                        k_reg <= k_reg + KW'(1);
                        if (k_reg == n_reg) begin
                            issue_reg <= 1'b0;
                        end
                    end
                    if (run_done) begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, phase_out_reg, value_out_reg};
    assign m_tuser  = sat_out_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted while a sample is in progress");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_reg |-> (k_reg != '0) && (k_reg <= n_reg))
        else $error("harmonic index out of range");

    a_mac_only_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg || mac_busy) |-> (state_reg == ST_RUN))
        else $error("MAC activity outside the run phase");

    a_phase_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_tdata[0] |=>
            phase_accum_reg == $past(phase_accum_reg + phase_step_reg))
        else $error("phase accumulator did not advance by phase_step");

endmodule

### sim/sqfs_sample_checker.sv
// ============================================================================
// sqfs_sample_checker
// Watches the register writes and both streams of the square wave
// synthesizer. Keeps its own copy of the registers and the phase, predicts
// every sample at request time and compares each returned sample field by field.
// ============================================================================
module sqfs_sample_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sqfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sqfs_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] restart
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [55:0]                    m_tdata,   // [19:0] sample_value,
                                                      // [51:20] sample_phase
    input  logic [0:0]                     m_tuser,   // [0] saturated
    output int                             mismatch_count,
    output int                             pending_samples
);
    timeunit 1ns;
    timeprecision 1ps;

    import sqfs_pkg::*;

    localparam int HARM_LIMIT = DEFAULT_MAX_HARMONICS;
    localparam int SINE_BITS  = DEFAULT_SINE_ADDR_BITS;
    localparam int SINE_SIZE  = 1 << SINE_BITS;
    localparam int QUARTER    = SINE_SIZE >> 2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PHASE_W-1:0]        phase;
        logic                      clipped;
    } sample_t;

    sample_t                   sample_queue [$];
    int                        sine_lut [SINE_SIZE];
    int unsigned               coeff_lut [1:HARM_LIMIT];

    logic [HARM_W-1:0]         harm_count;
    logic [PHASE_W-1:0]        phase_step;
    logic [PHASE_W-1:0]        start_phase;
    logic signed [VALUE_W-1:0] dc_offset;
    logic [PHASE_W-1:0]        phase_accum;

    // Q30 Taylor series through x^25, truncating at each step, rounded to Q16
    function automatic int quarter_wave(input int unsigned j);
        longint unsigned x;
        longint unsigned term;
        longint          s;
        x    = (64'd2 * PI_Q30 * 64'(j)) / 64'(SINE_SIZE);
        term = x;
        s    = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'(2 * n * (2 * n + 1));
            if (n % 2 == 1) begin
                s = s - longint'(term);
            end else begin
                s = s + longint'(term);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        s = (s + 8192) >>> 14;
        if (s > 65536) begin
            s = 65536;
        end
        return int'(s);
    endfunction

    initial begin
        int v;
        int quad;
        int r;
        for (int k = 1; k <= HARM_LIMIT; k++) begin
            if (k % 2 == 1) begin
                coeff_lut[k] = int'((((64'd1 << 48) / (PI_Q30 * 64'(k))) + 1) >> 1);
            end else begin
                coeff_lut[k] = 0;
            end
        end
        for (int j = 0; j < SINE_SIZE; j++) begin
            quad = j / QUARTER;
            r    = j % QUARTER;
            v    = (quad % 2 == 1) ? quarter_wave(QUARTER - r) : quarter_wave(r);
            sine_lut[j] = (quad >= 2) ? -v : v;
        end
    end

    // Sum of the harmonics at the current phase, then advance the phase
    function automatic sample_t synth_sample(input logic restart);
        sample_t            smp;
        longint             acc;
        longint             v;
        int                 n;
        logic [PHASE_W-1:0] ph;
        logic [PHASE_W-1:0] th;
        if (restart) begin
            phase_accum = start_phase;
        end
        ph  = phase_accum;
        n   = (int'(harm_count) > HARM_LIMIT) ? HARM_LIMIT : int'(harm_count);
        acc = 0;
        for (int k = 1; k <= n; k++) begin
            th  = ph * 32'(k);
            acc = acc + longint'(coeff_lut[k]) * longint'(sine_lut[th >> (PHASE_W - SINE_BITS)]);
        end
        v = ((acc + 32768) >>> 16) + longint'(dc_offset);
        smp.clipped = 1'b0;
        if (v > SAMPLE_MAX) begin
            v = SAMPLE_MAX;
            smp.clipped = 1'b1;
        end
        if (v < SAMPLE_MIN) begin
            v = SAMPLE_MIN;
            smp.clipped = 1'b1;
        end
        smp.value   = VALUE_W'(v);
        smp.phase   = ph;
        phase_accum = ph + phase_step;
        return smp;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: sample mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        sample_t want;
        if (!aresetn) begin
            harm_count  = RST_HARM_COUNT;
            phase_step  = RST_PHASE_STEP;
            start_phase = RST_START_PHASE;
            dc_offset   = RST_DC_OFFSET;
            phase_accum = '0;
            sample_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (reg_index_t'(cfg_index))
                    REG_HARM_COUNT:  harm_count  = cfg_wdata[HARM_W-1:0];
                    REG_PHASE_STEP:  phase_step  = cfg_wdata;
                    REG_START_PHASE: start_phase = cfg_wdata;
                    REG_DC_OFFSET:   dc_offset   = cfg_wdata[VALUE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                sample_queue.push_back(synth_sample(s_tdata[0]));
            end
            if (m_tvalid && m_tready) begin
                if (sample_queue.size() == 0) begin
                    report_mismatch("unexpected sample, phase", longint'(m_tdata[51:20]), -1);
                end else begin
                    want = sample_queue.pop_front();
                    if ($signed(m_tdata[19:0]) !== want.value) begin
                        report_mismatch("sample_value", longint'($signed(m_tdata[19:0])),
                                        longint'(want.value));
                    end
                    if (m_tdata[51:20] !== want.phase) begin
                        report_mismatch("sample_phase", longint'(m_tdata[51:20]),
                                        longint'(want.phase));
                    end
                    if (m_tuser[0] !== want.clipped) begin
                        report_mismatch("saturated", longint'(m_tuser[0]),
                                        longint'(want.clipped));
                    end
                end
            end
        end
        pending_samples <= sample_queue.size();
    end

endmodule

### sim/square_wave_fourier_synth_test.sv
// ============================================================================
// square_wave_fourier_synth_test
// Drives sample requests and register settings into the synthesizer: a short
// directed set at the register extremes, then random phases under varying
// back-pressure. The checker predicts and compares; this module gives the verdict.
// ============================================================================
module square_wave_fourier_synth_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sqfs_pkg::*;

    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int SETTLE_CYCLES  = 90;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 218;

    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_IDLE,
        FLOW_RECV_STALL,
        FLOW_BOTH
    } flow_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;
    logic [0:0]            m_tuser;

    int mismatch_count;
    int pending_samples;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    square_wave_fourier_synth dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    sqfs_sample_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .pending_samples (pending_samples)
    );

    always #1ns aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic set_flow(input flow_mode_t mode);
        case (mode)
            FLOW_FREE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            FLOW_SEND_IDLE: begin
                send_idle_pct  = 53;
                recv_stall_pct = 0;
            end
            FLOW_RECV_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 53;
            end
            default: begin
                send_idle_pct  = 13;
                recv_stall_pct = 13;
            end
        endcase
    endtask

    // tvalid stays high across back-to-back requests; it only drops in a gap
    task automatic send_request(input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_samples != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [HARM_W-1:0] harm, input logic [PHASE_W-1:0] step,
                                 input logic [PHASE_W-1:0] start,
                                 input logic [VALUE_W-1:0] dc);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_HARM_COUNT;
        cfg_wdata <= CFG_DAT_W'(harm);
        @(posedge aclk);
        cfg_index <= REG_PHASE_STEP;
        cfg_wdata <= step;
        @(posedge aclk);
        cfg_index <= REG_START_PHASE;
        cfg_wdata <= start;
        @(posedge aclk);
        cfg_index <= REG_DC_OFFSET;
        cfg_wdata <= CFG_DAT_W'(dc);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [HARM_W-1:0] pick_harm();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 12) return HARM_W'($urandom_range(65, 127));
        if (r < 30) return HARM_W'($urandom_range(21, 64));
        return HARM_W'($urandom_range(1, 20));
    endfunction

    function automatic logic [PHASE_W-1:0] pick_phase(input logic [PHASE_W-1:0] near);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 45) return near + PHASE_W'($urandom_range(0, 1 << 24));
        return PHASE_W'($urandom);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_dc();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 20'h7FFFF;
        if (r < 16) return 20'h80000;
        if (r < 40) return VALUE_W'($urandom);
        return VALUE_W'($urandom_range(0, 16383)) - 20'd8192;
    endfunction

    initial begin
        set_flow(FLOW_FREE);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults straight out of reset
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        // no harmonics: only the offset comes out
        drain();
        load_settings(7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'h7FFFF);
        send_request(1'b1);
        send_request(1'b0);

        // count above MAX_HARMONICS clamps; largest negative offset
        drain();
        load_settings(7'd127, 32'hFFFF_FFFF, 32'h0, 20'h80000);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);

        // full harmonic set at the quarter-wave peak, positive clip
        drain();
        load_settings(7'd64, 32'h4000_0000, 32'h4000_0000, 20'h7FFFF);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);

        // single harmonic, frozen phase
        drain();
        load_settings(7'd1, 32'h0, 32'h8000_0000, 20'hFFFFF);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);

        // even harmonic adds nothing
        drain();
        load_settings(7'd2, 32'h0080_0000, 32'h0, 20'h0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            logic [PHASE_W-1:0] start;
            drain();
            start = PHASE_W'($urandom);
            load_settings(pick_harm(), pick_phase('0), pick_phase(start), pick_dc());
            set_flow(flow_mode_t'(p % 4));
            repeat (PHASE_REQUESTS) send_request($urandom_range(0, 7) == 0);
        end

        drain();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
